FILE: hw/rtl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// shared types and constants of the 3x3 adjugate inverse
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int ElemW = 16;  // q8.8 element
  localparam int AdjW  = 32;  // q16.16 cofactor
  localparam int DpW   = 48;  // element times cofactor
  localparam int DetW  = 49;  // determinant, q.24
  localparam int MagW  = 48;  // determinant magnitude
  localparam int ThrW  = 25;  // zero threshold register
  localparam int NumW  = 57;  // 2 * |adj| * 2^24 + |det|
  localparam int DenW  = 49;  // 2 * |det|
  localparam int QuoW  = 33;  // kept quotient bits
  localparam int CntW  = 6;
  localparam logic [CntW-1:0] LastStep = CntW'(NumW - 1);

  // adj[k] = e[i0] * e[i1] - e[i2] * e[i3], elements row-major
  localparam logic [3:0] CofIdx [9][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  typedef logic [8:0][ElemW-1:0] mat_t;

  typedef struct packed {
    logic [8:0][AdjW-1:0] adj;
    logic [DetW-1:0]      det;
    logic                 singular;
  } item_t;

  typedef enum logic {
    BackIdle,
    BackDiv
  } back_state_e;

endpackage

FILE: hw/rtl/m3i_front.sv
// ----------------------------------------------------------------------------
// m3i_front
// cofactors, determinant and singular test, three register stages
// ----------------------------------------------------------------------------
module m3i_front import m3i_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  mat_t            mat_i,
  input  logic [ThrW-1:0] thr_i,
  output logic            out_valid_o,
  output item_t           item_o
);

  logic [17:0][AdjW-1:0]  prod_d, prod_q;
  logic [2:0][ElemW-1:0]  row0_1_q, row0_2_q;
  logic [8:0][AdjW-1:0]   adj_d, adj2_q, adj3_q;
  logic [2:0][DpW-1:0]    dp_d, dp_q;
  logic                   v1_q, v2_q, v3_q;
  logic signed [DetW-1:0] det;
  logic [DetW-1:0]        mag;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      prod_d[2*k]   = AdjW'($signed(mat_i[CofIdx[k][0]]) * $signed(mat_i[CofIdx[k][1]]));
      prod_d[2*k+1] = AdjW'($signed(mat_i[CofIdx[k][2]]) * $signed(mat_i[CofIdx[k][3]]));
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      adj_d[k] = prod_q[2*k] - prod_q[2*k+1];
    end
    for (int j = 0; j < 3; j++) begin
      dp_d[j] = DpW'($signed(row0_2_q[j]) * $signed(adj2_q[3*j]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    row0_1_q <= mat_i[2:0];
    adj2_q   <= adj_d;
    row0_2_q <= row0_1_q;
    adj3_q   <= adj2_q;
    dp_q     <= dp_d;
  end

  // determinant and magnitude test
  assign det = DetW'($signed(dp_q[0])) + DetW'($signed(dp_q[1])) + DetW'($signed(dp_q[2]));
  assign mag = det[DetW-1] ? DetW'(-det) : DetW'(det);

  assign out_valid_o     = v3_q;
  assign item_o.adj      = adj3_q;
  assign item_o.det      = det;
  assign item_o.singular = (mag <= DetW'(thr_i));

endmodule

FILE: hw/rtl/m3i_queue.sv
// ----------------------------------------------------------------------------
// m3i_queue
// small fifo between front and back
// ----------------------------------------------------------------------------
module m3i_queue import m3i_pkg::*; #(
  parameter int Depth = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  valid_o,
  output logic  full_o,
  output item_t item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    bump = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= bump(wr_q);
      if (pop_i)  rd_q <= bump(rd_q);
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign item_o  = mem_q[rd_q];

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o || pop_i)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("queue count out of range");

endmodule

FILE: hw/rtl/m3i_back.sv
// ----------------------------------------------------------------------------
// m3i_back
// nine bit-serial dividers with rounding and saturation
// ----------------------------------------------------------------------------
module m3i_back import m3i_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  item_t                q_item_i,
  output logic                 pop_o,
  output logic                 done_o,
  output logic [8:0][AdjW-1:0] inv_o,
  output logic                 singular_o
);

  back_state_e state_q, state_d;
  logic        load, finish;

  logic [8:0][NumW-1:0] n_q;
  logic [8:0][DenW-1:0] rem_q, rem_n;
  logic [8:0][QuoW-1:0] quo_q, quo_n;
  logic [8:0]           ovf_q, ovf_n, neg_q;
  logic [8:0][AdjW-1:0] res;
  logic [DenW-1:0]      den_q;
  logic [CntW-1:0]      cnt_q;
  logic                 done_q;
  logic [8:0][AdjW-1:0] inv_q;
  logic                 sing_q;

  logic [MagW-1:0]      det_mag;
  logic [DenW:0]        rem_sh, diff;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BackIdle: if (q_valid_i && !q_item_i.singular) state_d = BackDiv;
      BackDiv:  if (cnt_q == LastStep) state_d = BackIdle;
      default:  state_d = BackIdle;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    load   = 1'b0;
    finish = 1'b0;
    case (state_q)
      BackIdle: load   = q_valid_i;
      BackDiv:  finish = (cnt_q == LastStep);
      default: begin
        load   = 1'b0;
        finish = 1'b0;
      end
    endcase
  end

  assign pop_o   = load;
  assign det_mag = q_item_i.det[DetW-1] ? MagW'(-q_item_i.det) : MagW'(q_item_i.det);

  // one restoring step per lane, then round already folded in, saturate
  always_comb begin
    rem_sh = '0;
    diff   = '0;
    for (int i = 0; i < 9; i++) begin
      rem_sh   = {rem_q[i], n_q[i][NumW-1]};
      diff     = rem_sh - {1'b0, den_q};
      rem_n[i] = diff[DenW] ? rem_sh[DenW-1:0] : diff[DenW-1:0];
      quo_n[i] = {quo_q[i][QuoW-2:0], ~diff[DenW]};
      ovf_n[i] = ovf_q[i] | quo_q[i][QuoW-1];
      if (neg_q[i]) begin
        if (ovf_n[i] || quo_n[i][QuoW-1] || quo_n[i][AdjW-1]) res[i] = {1'b1, {(AdjW-1){1'b0}}};
        else res[i] = -quo_n[i][AdjW-1:0];
      end else begin
        if (ovf_n[i] || quo_n[i][QuoW-1] || quo_n[i][AdjW-1]) res[i] = {1'b0, {(AdjW-1){1'b1}}};
        else res[i] = quo_n[i][AdjW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BackIdle;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= finish || (load && q_item_i.singular);
      cnt_q   <= load ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      den_q <= {det_mag, 1'b0};
      for (int i = 0; i < 9; i++) begin
        n_q[i]   <= {(q_item_i.adj[i][AdjW-1] ? -q_item_i.adj[i] : q_item_i.adj[i]), 25'b0}
                    + {9'b0, det_mag};
        rem_q[i] <= '0;
        quo_q[i] <= '0;
        ovf_q[i] <= 1'b0;
        neg_q[i] <= q_item_i.adj[i][AdjW-1] ^ q_item_i.det[DetW-1];
      end
      if (q_item_i.singular) begin
        inv_q  <= q_item_i.adj;
        sing_q <= 1'b1;
      end
    end else begin
      for (int i = 0; i < 9; i++) begin
        n_q[i]   <= {n_q[i][NumW-2:0], 1'b0};
        rem_q[i] <= rem_n[i];
        quo_q[i] <= quo_n[i];
        ovf_q[i] <= ovf_n[i];
      end
      if (finish) begin
        inv_q  <= res;
        sing_q <= 1'b0;
      end
    end
  end

  assign done_o     = done_q;
  assign inv_o      = inv_q;
  assign singular_o = sing_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) state_q == BackDiv |-> !pop_o)
    else $error("pop while dividing");
  assert property (@(posedge clk_i) disable iff (!rst_ni) finish |=> done_o && !singular_o)
    else $error("finished divide not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(pop_o) || $past(finish))
    else $error("result without source");

endmodule

FILE: hw/rtl/matrix3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 matrix inverse by the adjugate, q8.8 in, q16.16 out
// ----------------------------------------------------------------------------
//  channel  | signals                          | handshake
//  ---------+----------------------------------+----------------------------
//  matrix   | start, busy, a00_i .. a22_i      | transaction at start & !busy
//  result   | done_o, inv00_o .. inv22_o,      | one-cycle strobe, no stall
//           | singular_o                       |
//  config   | cfg_valid_i, cfg_ready_o,        | transaction at valid & ready
//           | cfg_data_i                       |
//
//  front: three register stages (cofactor products, cofactors, det products),
//    then the determinant test feeds the queue; one matrix per cycle if !busy
//  back: a singular matrix leaves in the cycle after it is popped; otherwise
//    nine parallel bit-serial dividers run 57 steps before the next pop
//  busy rises when QueueDepth matrices sit in front and queue together
//  reset clears control only; threshold resets to 1
//  the receiver cannot stall: every result is shown for one cycle
// ----------------------------------------------------------------------------
module matrix3_inverse import m3i_pkg::*; #(
  parameter int QueueDepth = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [ElemW-1:0] a00_i,
  input  logic signed [ElemW-1:0] a01_i,
  input  logic signed [ElemW-1:0] a02_i,
  input  logic signed [ElemW-1:0] a10_i,
  input  logic signed [ElemW-1:0] a11_i,
  input  logic signed [ElemW-1:0] a12_i,
  input  logic signed [ElemW-1:0] a20_i,
  input  logic signed [ElemW-1:0] a21_i,
  input  logic signed [ElemW-1:0] a22_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [ThrW-1:0]        cfg_data_i,
  output logic                   done_o,
  output logic signed [AdjW-1:0] inv00_o,
  output logic signed [AdjW-1:0] inv01_o,
  output logic signed [AdjW-1:0] inv02_o,
  output logic signed [AdjW-1:0] inv10_o,
  output logic signed [AdjW-1:0] inv11_o,
  output logic signed [AdjW-1:0] inv12_o,
  output logic signed [AdjW-1:0] inv20_o,
  output logic signed [AdjW-1:0] inv21_o,
  output logic signed [AdjW-1:0] inv22_o,
  output logic                   singular_o
);

  localparam int PendW = $clog2(QueueDepth + 1);

  logic [ThrW-1:0]      thr_q;
  logic [PendW-1:0]     pend_q;
  logic                 accept, f_valid, q_valid, q_full, pop;
  mat_t                 mat;
  item_t                f_item, q_item;
  logic [8:0][AdjW-1:0] inv;

  // threshold register, always ready
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrW'(1);
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // credit count: matrices in the front pipe plus the queue
  assign busy   = (pend_q == PendW'(QueueDepth));
  assign accept = start && !busy;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + PendW'(accept) - PendW'(pop);
    end
  end

  assign mat = {a22_i, a21_i, a20_i, a12_i, a11_i, a10_i, a02_i, a01_i, a00_i};

  m3i_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .mat_i       (mat),
    .thr_i       (thr_q),
    .out_valid_o (f_valid),
    .item_o      (f_item)
  );

  m3i_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .item_i  (f_item),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .item_o  (q_item)
  );

  m3i_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .pop_o      (pop),
    .done_o     (done_o),
    .inv_o      (inv),
    .singular_o (singular_o)
  );

  assign inv00_o = inv[0];
  assign inv01_o = inv[1];
  assign inv02_o = inv[2];
  assign inv10_o = inv[3];
  assign inv11_o = inv[4];
  assign inv12_o = inv[5];
  assign inv20_o = inv[6];
  assign inv21_o = inv[7];
  assign inv22_o = inv[8];

  // credits keep the queue from overflowing
  assert property (@(posedge clk_i) disable iff (!rst_ni) f_valid && q_full |-> pop)
    else $error("front output with full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q <= PendW'(QueueDepth))
    else $error("credit count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> pend_q != '0)
    else $error("pop without credit");

endmodule
